>>> design/brb_pkg.sv
// Shared types and constants for the byte ring buffer.
package brb_pkg;

    localparam int CAP_W   = 11;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 11;
    localparam int LVL_W   = 10;

    // input mode codes
    localparam logic [1:0] MODE_WR_U = 2'd0;
    localparam logic [1:0] MODE_WR_C = 2'd1;
    localparam logic [1:0] MODE_RD   = 2'd2;

    // result status codes
    localparam logic [1:0] STS_STORED = 2'd0;
    localparam logic [1:0] STS_REJECT = 2'd1;
    localparam logic [1:0] STS_RDBYTE = 2'd2;
    localparam logic [1:0] STS_RDNONE = 2'd3;

    typedef struct packed {
        logic wr_u;      // unchecked write beat
        logic wr_c;      // checked write beat
        logic rd_start;  // read request with at least one byte
        logic rd_none;   // read request with nothing to return
        logic issue;     // fetch next byte from storage
        logic emit;      // load fetched byte into output register
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rd_zero;
        logic left_zero;
    } t_sts;

endpackage

>>> design/brb_ctrl.sv
// Controller state machine: input handshake and read sequencing.
module brb_ctrl
    import brb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    always_comb begin
        o_s_tready = (r_state == ST_IDLE) && i_sts.out_free;
        acc        = i_s_tvalid && o_s_tready;
        o_cmd      = '0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_u     = acc && (i_mode == MODE_WR_U);
                o_cmd.wr_c     = acc && (i_mode == MODE_WR_C);
                o_cmd.rd_start = acc && (i_mode == MODE_RD) && !i_sts.rd_zero;
                o_cmd.rd_none  = acc && (i_mode == MODE_RD) && i_sts.rd_zero;
                o_cmd.issue    = o_cmd.rd_start;
                if (o_cmd.rd_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.issue = i_sts.out_free && !i_sts.left_zero;
                if (i_sts.out_free && i_sts.left_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_last_byte_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && i_sts.out_free && i_sts.left_zero) |=> (r_state == ST_IDLE))
        else $error("read sequence did not end after last byte");
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !(o_cmd.wr_u || o_cmd.wr_c || o_cmd.rd_start))
        else $error("new item taken during read sequence");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");
`endif

endmodule

>>> design/brb_dp.sv
// Datapath: storage, indices, capacity, batch flag and output register.
module brb_dp
    import brb_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr,
    input  logic [CAP_W-1:0]   i_cfg_data,
    input  logic [DATA_W-1:0]  i_data_in,
    input  logic               i_batch_first,
    input  logic [COUNT_W-1:0] i_count,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [DATA_W-1:0]  o_data_out,
    output logic [1:0]         o_status,
    output logic [LVL_W-1:0]   o_used,
    output logic [LVL_W-1:0]   o_remain,
    output logic               o_empty,
    output logic               o_last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW0 = $clog2(DEPTH + 1);
    localparam int CW  = (CW0 > CAP_W) ? CW0 : CAP_W;
    localparam int NW  = $clog2(MAX_READ + 1);

    function automatic logic [AW-1:0] f_bump(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] cap);
        logic [CW-1:0] nx;
        nx = CW'(idx) + CW'(1);
        return (nx >= cap) ? '0 : nx[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] f_used(input logic [AW-1:0] w,
                                             input logic [AW-1:0] r,
                                             input logic [CW-1:0] cap);
        return (w >= r) ? (CW'(w) - CW'(r)) : (cap - CW'(r) + CW'(w));
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [AW-1:0] r_widx, n_widx;
    logic [AW-1:0] r_ridx, n_ridx;
    logic [CW-1:0] r_cap;
    logic          r_brej, n_brej;
    logic [NW-1:0] r_left, n_left;

    logic              r_ov;
    logic [DATA_W-1:0] r_dout;
    logic [1:0]        r_stat;
    logic [LVL_W-1:0]  r_used;
    logic [LVL_W-1:0]  r_rem;
    logic              r_empty;
    logic              r_last;

    logic [CW-1:0] used_cur, rem_cur, used_o, rem_o, rd_min, cfg_ext, cfg_cap;
    logic [NW-1:0] rd_n;
    logic          rej, store, load;

    always_comb begin
        used_cur = f_used(r_widx, r_ridx, r_cap);
        rem_cur  = r_cap - used_cur - CW'(1);

        rej    = i_batch_first ? (rem_cur < CW'(i_count)) : r_brej;
        store  = i_cmd.wr_u || (i_cmd.wr_c && !rej);
        n_brej = i_cmd.wr_c ? rej : r_brej;
        n_widx = store ? f_bump(r_widx, r_cap) : r_widx;
        n_ridx = i_cmd.issue ? f_bump(r_ridx, r_cap) : r_ridx;

        rd_min = (used_cur < CW'(i_count)) ? used_cur : CW'(i_count);
        rd_n   = (rd_min > CW'(MAX_READ)) ? NW'(MAX_READ) : rd_min[NW-1:0];

        // writes and read beats never coincide, so this pair is the post-result state
        used_o = f_used(n_widx, r_ridx, r_cap);
        rem_o  = r_cap - used_o - CW'(1);

        n_left = r_left;
        if (i_cmd.rd_start) begin
            n_left = rd_n - NW'(1);
        end else if (i_cmd.emit && r_left != '0) begin
            n_left = r_left - NW'(1);
        end

        load = i_cmd.wr_u || i_cmd.wr_c || i_cmd.rd_none || i_cmd.emit;

        cfg_ext = CW'(i_cfg_data);
        if (cfg_ext < CW'(2)) begin
            cfg_cap = CW'(2);
        end else if (cfg_ext > CW'(DEPTH)) begin
            cfg_cap = CW'(DEPTH);
        end else begin
            cfg_cap = cfg_ext;
        end

        o_sts.out_free  = !r_ov || i_m_tready;
        o_sts.rd_zero   = (rd_n == '0);
        o_sts.left_zero = (r_left == '0);
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            mem[r_widx] <= i_data_in;
        end
        if (i_cmd.issue) begin
            r_rdata <= mem[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_ridx <= '0;
            r_brej <= 1'b0;
            r_cap  <= CW'(DEPTH);
            r_left <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_widx <= '0;
                r_ridx <= '0;
                r_brej <= 1'b0;
                r_cap  <= cfg_cap;
            end else begin
                r_widx <= n_widx;
                r_ridx <= n_ridx;
                r_brej <= n_brej;
            end
            r_left <= n_left;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dout  <= i_cmd.emit ? r_rdata : '0;
            r_used  <= used_o[LVL_W-1:0];
            r_rem   <= rem_o[LVL_W-1:0];
            r_empty <= (n_widx == r_ridx);
            r_last  <= i_cmd.emit ? (r_left == '0) : 1'b1;
            priority if (i_cmd.emit) begin
                r_stat <= STS_RDBYTE;
            end else if (i_cmd.rd_none) begin
                r_stat <= STS_RDNONE;
            end else if (i_cmd.wr_c && rej) begin
                r_stat <= STS_REJECT;
            end else begin
                r_stat <= STS_STORED;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_data_out = r_dout;
    assign o_status   = r_stat;
    assign o_used     = r_used;
    assign o_remain   = r_rem;
    assign o_empty    = r_empty;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_widx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_widx) < r_cap)
        else $error("write index beyond capacity");
    a_ridx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_ridx) < r_cap)
        else $error("read index beyond capacity");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_ov || i_m_tready))
        else $error("output register overwritten while held");
    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store && i_cmd.issue))
        else $error("store and fetch in the same cycle");
`endif

endmodule

>>> design/byte_ring_buffer.sv
// Byte ring buffer top level: stream ports, config channel, controller and datapath.
// Write items (checked or unchecked) are taken one item per cycle while the result side accepts.
// A read of n bytes (n = min(used, count, MAX_READ)) fetches the first byte through the
// registered storage read port, then returns one byte per cycle while the result side
// accepts. Results pass through one output register.
// Synchronous active-low reset clears indices, batch flag, capacity (to DEPTH), and the
// output valid; storage is not cleared and holds no value until written.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,   // capacity
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // data_in[7:0], count[18:8], zero[23:19]
    input  logic [2:0]  i_s_tuser,    // mode[1:0], batch_first[2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // data_out[7:0], used_count[17:8], remain_count[27:18], zero[31:28]
    output logic [2:0]  o_m_tuser,    // status[1:0], empty_res[2]
    output logic        o_m_tlast
);

    t_cmd cmd;
    t_sts sts;

    logic [DATA_W-1:0] data_out;
    logic [1:0]        status;
    logic [LVL_W-1:0]  used;
    logic [LVL_W-1:0]  remain;
    logic              empty;

    assign o_cfg_ready = 1'b1;

    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser[1:0]),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    brb_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_data_in     (i_s_tdata[7:0]),
        .i_batch_first (i_s_tuser[2]),
        .i_count       (i_s_tdata[18:8]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_data_out    (data_out),
        .o_status      (status),
        .o_used        (used),
        .o_remain      (remain),
        .o_empty       (empty),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, remain, used, data_out};
    assign o_m_tuser = {empty, status};

endmodule

>>> bench/brb_checker.sv
// Byte ring buffer checker: mirrors the ring, predicts result beats and compares them.
module brb_checker
    import brb_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,   // capacity
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,    // data_in[7:0], count[18:8], zero[23:19]
    input  logic [2:0]  i_s_tuser,    // mode[1:0], batch_first[2]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // data_out[7:0], used_count[17:8], remain_count[27:18]
    input  logic [2:0]  i_m_tuser,    // status[1:0], empty_res[2]
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic [LVL_W-1:0]  used;
        logic [LVL_W-1:0]  remain;
        logic              empty;
        logic              last;
    } t_ring_beat;

    logic [DATA_W-1:0] ring_mem [DEPTH];
    int unsigned       ring_cap    = DEPTH;
    int unsigned       ring_wr     = 0;
    int unsigned       ring_rd     = 0;
    logic              ring_reject = 1'b0;
    t_ring_beat        ring_results_q [$];
    int                errs = 0;

    // capacity as the ring actually uses it
    function automatic int unsigned slots();
        if (ring_cap < 2) return 2;
        if (ring_cap > DEPTH) return DEPTH;
        return ring_cap;
    endfunction

    function automatic int unsigned fill();
        if (ring_wr >= ring_rd) return ring_wr - ring_rd;
        return slots() - ring_rd + ring_wr;
    endfunction

    function automatic int unsigned next_slot(input int unsigned idx);
        return (idx + 1 >= slots()) ? 0 : idx + 1;
    endfunction

    function automatic void ring_put(input logic [DATA_W-1:0] data);
        ring_mem[ring_wr] = data;
        ring_wr = next_slot(ring_wr);
    endfunction

    function automatic void post_result(input logic [DATA_W-1:0] data, input logic [1:0] status,
                                        input logic last);
        t_ring_beat  b;
        int unsigned u;
        u        = fill();
        b.data   = data;
        b.status = status;
        b.used   = LVL_W'(u);
        b.remain = LVL_W'(slots() - u - 1);
        b.empty  = (ring_wr == ring_rd);
        b.last   = last;
        ring_results_q.push_back(b);
    endfunction

    function automatic void ring_step(input logic [1:0] mode, input logic [DATA_W-1:0] data,
                                      input logic first, input int unsigned count);
        int unsigned n;
        int unsigned k;
        case (mode)
            MODE_WR_U: begin
                ring_put(data);
                post_result('0, STS_STORED, 1'b1);
            end
            MODE_WR_C: begin
                // batch decision is taken on the first byte and held for the rest
                if (first) ring_reject = (slots() - fill() - 1) < count;
                if (ring_reject) begin
                    post_result('0, STS_REJECT, 1'b1);
                end else begin
                    ring_put(data);
                    post_result('0, STS_STORED, 1'b1);
                end
            end
            MODE_RD: begin
                n = fill();
                if (n > count) n = count;
                if (n > MAX_READ) n = MAX_READ;
                if (n == 0) begin
                    post_result('0, STS_RDNONE, 1'b1);
                end else begin
                    for (k = 0; k < n; k++) begin
                        data    = ring_mem[ring_rd];
                        ring_rd = next_slot(ring_rd);
                        post_result(data, STS_RDBYTE, k + 1 == n);
                    end
                end
            end
            default: ;  // unused mode, no results
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_ring_beat got;
        t_ring_beat want;
        if (!i_rst_n) begin
            ring_cap    = DEPTH;
            ring_wr     = 0;
            ring_rd     = 0;
            ring_reject = 1'b0;
            ring_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ring_cap    = i_cfg_data;
                ring_wr     = 0;
                ring_rd     = 0;
                ring_reject = 1'b0;
            end
            if (i_s_tvalid && i_s_tready)
                ring_step(i_s_tuser[1:0], i_s_tdata[7:0], i_s_tuser[2], i_s_tdata[18:8]);
            if (i_m_tvalid && i_m_tready) begin
                got.data   = i_m_tdata[7:0];
                got.used   = i_m_tdata[17:8];
                got.remain = i_m_tdata[27:18];
                got.status = i_m_tuser[1:0];
                got.empty  = i_m_tuser[2];
                got.last   = i_m_tlast;
                if (ring_results_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result beat with nothing pending: data %h sts %0d",
                                 $realtime, got.data, got.status);
                end else begin
                    want = ring_results_q.pop_front();
                    if (got.data !== want.data || got.status !== want.status ||
                        got.used !== want.used || got.remain !== want.remain ||
                        got.empty !== want.empty || got.last !== want.last) begin
                        errs++;
                        if (errs <= 10)
                            $display({"%0t: mismatch exp data %h sts %0d used %0d rem %0d ",
                                      "empty %b last %b / got data %h sts %0d used %0d ",
                                      "rem %0d empty %b last %b"}, $realtime,
                                     want.data, want.status, want.used, want.remain,
                                     want.empty, want.last, got.data, got.status,
                                     got.used, got.remain, got.empty, got.last);
                    end
                end
            end
        end
        o_mismatches = errs;
        o_pending    = ring_results_q.size();
    end

endmodule

>>> bench/tb_byte_ring_buffer.sv
// Byte ring buffer bench top: clock, reset, stream and config stimulus, final verdict.
module tb_byte_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    localparam int      DEPTH       = 1024;
    localparam int      MAX_READ    = 64;
    localparam int      GAP_MAX     = 18;
    localparam int      HOLD_CYCLES = 300;
    localparam int      SETTLE      = 4;    // output register plus an ignored beat
    localparam int      TAIL        = 20;
    localparam int      RAND_ITEMS  = 200;
    localparam longint  LIMIT       = 2_500_000;

    localparam logic [1:0] MODE_NONE = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          pending;

    logic        tx_idle_en = 1'b1;
    logic        rx_idle_en = 1'b1;
    logic        hold_req   = 1'b0;
    int unsigned slots_now  = DEPTH;
    int unsigned cap_corner [7] = '{2, 1024, 0, 3, 1025, 1, 2047};

    byte_ring_buffer #(.DEPTH(DEPTH), .MAX_READ(MAX_READ)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    brb_checker #(.DEPTH(DEPTH), .MAX_READ(MAX_READ)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // result side: random stalls per beat, plus one long hold-off on request
    initial begin : rx_side
        int stall;
        @(negedge clk);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid && !hold_req);
            @(negedge clk);
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [10:0] rnd_count();
        return 11'($urandom_range(0, 2047));
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic [7:0] data,
                             input logic first, input logic [10:0] count);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, count, data};
        s_tuser  <= {first, mode};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering and let every predicted beat drain out
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [10:0] value);
        settle(SETTLE);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        slots_now = (value < 2) ? 2 : (value > DEPTH) ? DEPTH : value;
    endtask

    initial begin : stimulus
        int items;
        int budget;
        int phase;
        int pick;
        int cnt;
        int len;
        int k;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset capacity, empty reads, count extremes, batches
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd0);
        send_beat(MODE_RD,   8'hFF, 1'b1, 11'd2047);
        send_beat(MODE_WR_U, 8'h00, 1'b0, 11'd0);
        send_beat(MODE_WR_U, 8'hFF, 1'b1, 11'd2047);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd0);
        send_beat(MODE_NONE, 8'hAA, 1'b1, 11'd5);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd1);
        send_beat(MODE_WR_C, 8'h5A, 1'b1, 11'd3);
        send_beat(MODE_WR_C, 8'hA5, 1'b0, 11'd0);
        send_beat(MODE_WR_C, 8'h3C, 1'b0, 11'd2047);
        send_beat(MODE_WR_C, 8'h11, 1'b1, 11'd2047);
        send_beat(MODE_WR_C, 8'h22, 1'b0, 11'd1);
        send_beat(MODE_WR_C, 8'h33, 1'b1, 11'd0);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd2047);

        // capacity below range: two slots, one usable
        set_capacity(11'd0);
        send_beat(MODE_WR_C, 8'h44, 1'b1, 11'd1);
        send_beat(MODE_WR_C, 8'h55, 1'b1, 11'd1);
        send_beat(MODE_WR_U, 8'h77, 1'b0, 11'd0);   // overwrite, ring looks empty again
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd5);
        send_beat(MODE_WR_U, 8'h88, 1'b0, 11'd0);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd1);

        set_capacity(11'd1);
        send_beat(MODE_WR_C, 8'h99, 1'b1, 11'd2);
        send_beat(MODE_WR_U, 8'h66, 1'b0, 11'd0);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd3);

        // capacity above range: clamps to full depth
        set_capacity(11'd2047);
        send_beat(MODE_WR_C, 8'hC3, 1'b1, 11'd1023);
        send_beat(MODE_RD,   8'h00, 1'b0, 11'd1);

        // back-pressure: receiver holds off while writes stream in, then long reads
        set_capacity(11'd1024);
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (80) send_beat(MODE_WR_U, rnd_byte(), 1'b0, rnd_count());
        send_beat(MODE_RD, 8'h00, 1'b0, 11'd100);
        send_beat(MODE_RD, 8'h00, 1'b0, 11'd2047);
        send_beat(MODE_RD, 8'h00, 1'b0, 11'd9);
        settle(SETTLE);
        tx_idle_en = 1'b1;

        // random phases, each under its own capacity and idling mix
        items = 0;
        phase = 0;
        while (items < RAND_ITEMS) begin
            if (phase < 7)
                set_capacity(11'(cap_corner[phase]));
            else if ($urandom_range(0, 4) == 0)
                set_capacity(rnd_count());
            else
                set_capacity(11'($urandom_range(2, 24)));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            budget = items + $urandom_range(15, 30);
            while (items < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, slots_now);
                    len = (cnt == 0) ? 1 : cnt;
                    // long batches and some short ones are cut off early
                    if (len > 12 || $urandom_range(0, 9) == 0)
                        len = $urandom_range(1, 12);
                    send_beat(MODE_WR_C, rnd_byte(), 1'b1, 11'(cnt));
                    for (k = 1; k < len; k++)
                        send_beat(MODE_WR_C, rnd_byte(), 1'b0, rnd_count());
                    items += len;
                end else if (pick < 60) begin
                    len = $urandom_range(1, 8);
                    repeat (len)
                        send_beat(MODE_WR_U, rnd_byte(), 1'($urandom_range(0, 1)), rnd_count());
                    items += len;
                end else if (pick < 90) begin
                    cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 70);
                    send_beat(MODE_RD, rnd_byte(), 1'($urandom_range(0, 1)), 11'(cnt));
                    items++;
                end else if (pick < 95) begin
                    send_beat(MODE_WR_C, rnd_byte(), 1'b0, rnd_count());
                    items++;
                end else begin
                    send_beat(MODE_NONE, rnd_byte(), 1'($urandom_range(0, 1)), rnd_count());
                end
            end
            phase++;
        end

        settle(TAIL);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
